// ===== src/rla_pkg.sv =====
// Package with shared types and constants for the rate limited rudder actuator.
`default_nettype none

package rla_pkg;

  localparam int POS_W    = 16;
  localparam int DIFF_W   = 18;
  localparam int MAG_W    = 17;
  localparam int VEL_W    = 21;
  localparam int CUR_W    = 12;
  localparam int MV_W     = 13;
  localparam int STEP_W   = 15;
  localparam int LIM_W    = 15;
  localparam int TMO_W    = 16;
  localparam int RATE_W   = 10;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 3;
  localparam int MUL_A_W  = 18;
  localparam int MUL_B_W  = 14;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int FRAC_W   = 14;
  localparam int DIV_STEPS = CUR_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int DIVIDEND_W = 27;

  localparam logic [CUR_W-1:0]  CURRENT_FULL_MA = 12'd3000;
  localparam logic [MV_W-1:0]   SENSOR_MAX      = 13'd8191;

  localparam logic [IDX_W-1:0] REG_STEP_PER_TICK = 3'd0;
  localparam logic [IDX_W-1:0] REG_POSITION_LIM  = 3'd1;
  localparam logic [IDX_W-1:0] REG_WATCHDOG_TMO  = 3'd2;
  localparam logic [IDX_W-1:0] REG_TICK_RATE     = 3'd3;
  localparam logic [IDX_W-1:0] REG_CAL_CENTER    = 3'd4;
  localparam logic [IDX_W-1:0] REG_CAL_PORT      = 3'd5;
  localparam logic [IDX_W-1:0] REG_CAL_STBD      = 3'd6;

  localparam logic [STEP_W-1:0] STEP_RESET   = 15'd56;
  localparam logic [LIM_W-1:0]  LIMIT_RESET  = 15'd14746;
  localparam logic [TMO_W-1:0]  TMO_RESET    = 16'd2000;
  localparam logic [RATE_W-1:0] RATE_RESET   = 10'd20;
  localparam logic [MV_W-1:0]   CENTER_RESET = 13'd1650;
  localparam logic [MV_W-1:0]   PORT_RESET   = 13'd330;
  localparam logic [MV_W-1:0]   STBD_RESET   = 13'd2970;

  typedef enum logic [1:0] {
    MUL_VEL = 2'd0,
    MUL_SNS = 2'd1,
    MUL_CUR = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     update;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     latch_vel;
    logic     latch_sns;
    logic     div_init;
    logic     div_step;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/rla_ctrl.sv =====
// Controller state machine that sequences one control tick through the datapath.
`default_nettype none

module rla_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rla_pkg::dp_status_t status,
  output rla_pkg::ctrl_cmd_t  cmd
);
  import rla_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_STEP  = 8'b0000_0010,
    S_MVEL  = 8'b0000_0100,
    S_MSNS  = 8'b0000_1000,
    S_MCUR  = 8'b0001_0000,
    S_DINIT = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_CNT_W-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.mul_sel = MUL_VEL;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_STEP;
        end
      end
      S_STEP: begin
        cmd.update = 1'b1;
        state_next = S_MVEL;
      end
      S_MVEL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_VEL;
        state_next  = S_MSNS;
      end
      S_MSNS: begin
        cmd.latch_vel = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_SNS;
        state_next    = S_MCUR;
      end
      S_MCUR: begin
        cmd.latch_sns = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_CUR;
        state_next    = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!status.out_full) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/rla_datapath.sv =====
// Datapath with configuration registers, actuator state, shared multiplier and current divider.
`default_nettype none

module rla_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  rla_pkg::ctrl_cmd_t                cmd,
  output rla_pkg::dp_status_t               status,
  input  logic                              cfg_we,
  input  logic [rla_pkg::IDX_W-1:0]         cfg_index,
  input  logic [rla_pkg::CFG_W-1:0]         cfg_data,
  input  logic signed [rla_pkg::POS_W-1:0]  target_pos,
  input  logic                              clutch_request,
  input  logic [rla_pkg::TMO_W-1:0]         pilot_age_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rla_pkg::POS_W-1:0]  position,
  output logic signed [rla_pkg::VEL_W-1:0]  velocity,
  output logic [rla_pkg::CUR_W-1:0]         motor_current_ma,
  output logic [rla_pkg::MV_W-1:0]          sensor_mv,
  output logic                              engaged,
  output logic                              fault,
  output logic                              request_dropped
);
  import rla_pkg::*;

  logic [STEP_W-1:0] step_per_tick;
  logic [LIM_W-1:0]  position_limit;
  logic [TMO_W-1:0]  wd_timeout;
  logic [RATE_W-1:0] tick_rate_hz;
  logic [MV_W-1:0]   cal_center_mv;
  logic [MV_W-1:0]   cal_port_mv;
  logic [MV_W-1:0]   cal_stbd_mv;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_per_tick  <= STEP_RESET;
      position_limit <= LIMIT_RESET;
      wd_timeout     <= TMO_RESET;
      tick_rate_hz   <= RATE_RESET;
      cal_center_mv  <= CENTER_RESET;
      cal_port_mv    <= PORT_RESET;
      cal_stbd_mv    <= STBD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_PER_TICK: step_per_tick  <= cfg_data[STEP_W-1:0];
        REG_POSITION_LIM:  position_limit <= cfg_data[LIM_W-1:0];
        REG_WATCHDOG_TMO:  wd_timeout     <= cfg_data[TMO_W-1:0];
        REG_TICK_RATE:     tick_rate_hz   <= cfg_data[RATE_W-1:0];
        REG_CAL_CENTER:    cal_center_mv  <= cfg_data[MV_W-1:0];
        REG_CAL_PORT:      cal_port_mv    <= cfg_data[MV_W-1:0];
        REG_CAL_STBD:      cal_stbd_mv    <= cfg_data[MV_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured input item.
  logic signed [POS_W-1:0] tgt;
  logic                    req_in;
  logic [TMO_W-1:0]        age;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tgt    <= target_pos;
      req_in <= clutch_request;
      age    <= pilot_age_ms;
    end
  end

  // Watchdog, clutch and rate limited position update.
  logic signed [POS_W-1:0]  pos_reg;
  logic                     clutch_on;
  logic                     fault_state;
  logic                     dropped;
  logic signed [DIFF_W-1:0] delta;

  logic                     wd_fire;
  logic                     req_eff;
  logic                     fault_next;
  logic signed [DIFF_W-1:0] err;
  logic signed [DIFF_W-1:0] stp_s;
  logic signed [DIFF_W-1:0] lim_s;
  logic signed [DIFF_W-1:0] pos_x;
  logic signed [DIFF_W-1:0] p_next;

  always_comb begin
    wd_fire = (age > wd_timeout) && clutch_on;
    req_eff = req_in && !wd_fire;
    if (wd_fire) begin
      fault_next = 1'b1;
    end else if (req_eff && !clutch_on) begin
      fault_next = 1'b0;
    end else begin
      fault_next = fault_state;
    end
    pos_x = DIFF_W'(pos_reg);
    stp_s = signed'({{(DIFF_W-STEP_W){1'b0}}, step_per_tick});
    lim_s = signed'({{(DIFF_W-LIM_W){1'b0}}, position_limit});
    err   = DIFF_W'(tgt) - pos_x;
    if (err > stp_s) begin
      p_next = pos_x + stp_s;
    end else if (err < -stp_s) begin
      p_next = pos_x - stp_s;
    end else begin
      p_next = DIFF_W'(tgt);
    end
    if (p_next > lim_s) begin
      p_next = lim_s;
    end
    if (p_next < -lim_s) begin
      p_next = -lim_s;
    end
    if (!req_eff) begin
      p_next = pos_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_reg     <= '0;
      clutch_on   <= 1'b0;
      fault_state <= 1'b0;
    end else if (cmd.update) begin
      pos_reg     <= p_next[POS_W-1:0];
      clutch_on   <= req_eff;
      fault_state <= fault_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      dropped <= wd_fire;
      delta   <= p_next - pos_x;
    end
  end

  logic [MAG_W-1:0]         mag;
  logic signed [DIFF_W-1:0] delta_abs;

  always_comb begin
    delta_abs = (delta < 0) ? -delta : delta;
    mag       = delta_abs[MAG_W-1:0];
  end

  // Shared multiplier with registered product.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [MUL_B_W-1:0] span;

  always_comb begin
    if (pos_reg >= 0) begin
      span = signed'({1'b0, cal_stbd_mv}) - signed'({1'b0, cal_center_mv});
    end else begin
      span = signed'({1'b0, cal_center_mv}) - signed'({1'b0, cal_port_mv});
    end
    case (cmd.mul_sel)
      MUL_VEL: begin
        mul_a = delta;
        mul_b = signed'({{(MUL_B_W-RATE_W){1'b0}}, tick_rate_hz});
      end
      MUL_SNS: begin
        mul_a = MUL_A_W'(pos_reg);
        mul_b = span;
      end
      MUL_CUR: begin
        mul_a = signed'({{(MUL_A_W-MAG_W){1'b0}}, mag});
        mul_b = signed'({{(MUL_B_W-CUR_W){1'b0}}, CURRENT_FULL_MA});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // Velocity saturation and sensor interpolation from the product.
  localparam logic signed [PROD_W-1:0] VEL_MAX = PROD_W'((1 << (VEL_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] VEL_MIN = -PROD_W'(1 << (VEL_W - 1));

  logic signed [VEL_W-1:0]  vel;
  logic [MV_W-1:0]          sns;
  logic signed [PROD_W:0]   num;
  logic [PROD_W-FRAC_W:0]   mv_full;

  always_comb begin
    num     = signed'({{(PROD_W - MV_W - FRAC_W + 1){1'b0}}, cal_center_mv,
                       {FRAC_W{1'b0}}}) + (PROD_W + 1)'(prod);
    mv_full = num[PROD_W:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_vel) begin
      if (prod > VEL_MAX) begin
        vel <= VEL_MAX[VEL_W-1:0];
      end else if (prod < VEL_MIN) begin
        vel <= VEL_MIN[VEL_W-1:0];
      end else begin
        vel <= prod[VEL_W-1:0];
      end
    end
    if (cmd.latch_sns) begin
      if (num <= 0) begin
        sns <= '0;
      end else if (mv_full > (PROD_W - FRAC_W + 1)'(SENSOR_MAX)) begin
        sns <= SENSOR_MAX;
      end else begin
        sns <= mv_full[MV_W-1:0];
      end
    end
  end

  // Restoring divider for mag * 3000 / step, one quotient bit per cycle.
  logic [STEP_W-1:0] rem;
  logic [CUR_W-1:0]  quo;
  logic [STEP_W:0]   trial;
  logic              qbit;

  always_comb begin
    trial = {rem, quo[CUR_W-1]};
    qbit  = trial >= {1'b0, step_per_tick};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= prod[DIVIDEND_W-1:CUR_W];
      quo <= prod[CUR_W-1:0];
    end else if (cmd.div_step) begin
      rem <= qbit ? STEP_W'(trial - {1'b0, step_per_tick}) : trial[STEP_W-1:0];
      quo <= {quo[CUR_W-2:0], qbit};
    end
  end

  logic [CUR_W-1:0] current;

  always_comb begin
    if (!clutch_on || step_per_tick == '0) begin
      current = '0;
    end else if (mag > MAG_W'(step_per_tick)) begin
      current = CURRENT_FULL_MA;
    end else begin
      current = quo;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      position         <= pos_reg;
      velocity         <= vel;
      motor_current_ma <= current;
      sensor_mv        <= sns;
      engaged          <= clutch_on;
      fault            <= fault_state;
      request_dropped  <= dropped;
    end
  end

  assign status.out_full = out_valid && !out_ready;

endmodule

`default_nettype wire

// ===== src/rate_limited_rudder_actuator.sv =====
// Top level of the rate limited rudder actuator.
// Each input transfer is one control tick and yields exactly one result transfer. A tick
// passes from its input transfer to the output register through these steps in order: one
// update step, three passes through the shared 18x14 multiplier, one divider setup step, the
// bit-serial divider that forms the 12-bit motor current one quotient bit at a time, and the
// step that loads the result. A new tick is taken the cycle after the previous result is
// loaded, even while that result waits for out_ready; a result still waiting when the next
// one is ready holds the block until it is taken.
// Configuration writes land at once and are meant for times when no tick is in flight.
`default_nettype none

module rate_limited_rudder_actuator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rla_pkg::IDX_W-1:0]         cfg_index,
  input  logic [rla_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [rla_pkg::POS_W-1:0]  target_pos,
  input  logic                              clutch_request,
  input  logic [rla_pkg::TMO_W-1:0]         pilot_age_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rla_pkg::POS_W-1:0]  position,
  output logic signed [rla_pkg::VEL_W-1:0]  velocity,
  output logic [rla_pkg::CUR_W-1:0]         motor_current_ma,
  output logic [rla_pkg::MV_W-1:0]          sensor_mv,
  output logic                              engaged,
  output logic                              fault,
  output logic                              request_dropped
);
  import rla_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  rla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rla_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .target_pos       (target_pos),
    .clutch_request   (clutch_request),
    .pilot_age_ms     (pilot_age_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .position         (position),
    .velocity         (velocity),
    .motor_current_ma (motor_current_ma),
    .sensor_mv        (sensor_mv),
    .engaged          (engaged),
    .fault            (fault),
    .request_dropped  (request_dropped)
  );

endmodule

`default_nettype wire
